@@ hdl/grt_pkg.sv @@
// Shared constants, types and saturation helpers for the grid ray traversal block.
package grt_pkg;

  localparam int MAX_MAP_WIDTH  = 64;
  localparam int MAX_MAP_HEIGHT = 64;
  localparam int STORE_DEPTH    = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int COL_W          = $clog2(MAX_MAP_WIDTH);
  localparam int ROW_W          = $clog2(MAX_MAP_HEIGHT);
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int STEP_LIMIT     = MAX_MAP_WIDTH + MAX_MAP_HEIGHT + 4;
  localparam int STEP_CNT_W     = $clog2(STEP_LIMIT + 1);
  localparam int DIV_STEPS      = 32;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WALL_SIZE  = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef logic [31:0] len_t;

  function automatic len_t sat_add(input len_t a, input len_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage

@@ hdl/grid_ray_traversal_dda_top.sv @@
// Grid ray traversal (DDA): tile store, shared divider and multiplier, step sequencer.
// Map write: accepted while the sequencer is idle, no result.
// Cast: four divider passes, then the multiplier states, then a step and a tile check
//   per grid step; one cast at a time, requests stall until the sequencer is idle.
// Reset (rst, synchronous): sequencer idle, no result pending, registers to 64.
// The tile store is not cleared; cells must be written before rays read them.
module grid_ray_traversal_dda_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        kind,
  input  logic [11:0] cell_index,
  input  logic [7:0]  cell_value,
  input  logic [23:0] origin_x,
  input  logic [23:0] origin_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        hit,
  output logic [5:0]  hit_col,
  output logic [5:0]  hit_row,
  output logic [7:0]  wall_kind,
  output logic [31:0] ray_distance,
  output logic        x_side
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MLX, S_MLY, S_MSX, S_MSY, S_MEND, S_STEP, S_CHK, S_DONE
  } state_t;

  state_t state;

  logic [6:0] map_width, map_height;
  logic [7:0] wall_size;

  logic [23:0] px, py;
  logic        nx, ny;
  logic [15:0] mx, my;
  grt_pkg::len_t ux, uy, lx, ly, sx, sy, run_len;
  logic [19:0] bx, by;
  logic signed [13:0] col, row;
  logic        xs;
  logic        found;
  logic [7:0]  found_kind;
  logic [grt_pkg::STEP_CNT_W-1:0] steps;

  logic [31:0] dq;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [1:0]  div_sel;
  logic [grt_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [31:0] mul_a;
  logic [19:0] mul_b;
  logic [51:0] prod;

  logic [7:0] tile_mem [grt_pkg::STORE_DEPTH];
  logic [7:0] rdata;
  logic       mem_we;
  logic [grt_pkg::ADDR_W-1:0] raddr;

  logic [7:0] ws;
  logic [6:0] w_eff, h_eff;
  logic       accept;
  logic [16:0] trial;
  logic        qbit;
  logic [16:0] rem_next;
  logic [31:0] dq_next;
  logic [15:0] mx_in, my_in;
  logic [11:0] frac_x, frac_y;
  logic        step_x;
  logic signed [13:0] col_next, row_next;
  logic        leave;
  grt_pkg::len_t lx_sat, s_sat;

  assign ws    = (wall_size == 8'd0) ? 8'd1 : wall_size;
  assign w_eff = (map_width  > 7'(grt_pkg::MAX_MAP_WIDTH))  ? 7'(grt_pkg::MAX_MAP_WIDTH)
                                                            : map_width;
  assign h_eff = (map_height > 7'(grt_pkg::MAX_MAP_HEIGHT)) ? 7'(grt_pkg::MAX_MAP_HEIGHT)
                                                            : map_height;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign mem_we    = accept && (kind == grt_pkg::KIND_WRITE);

  assign mx_in = dir_x[15] ? 16'(~dir_x + 16'sd1) : dir_x;
  assign my_in = dir_y[15] ? 16'(~dir_y + 16'sd1) : dir_y;
  assign frac_x = px[11:0];
  assign frac_y = py[11:0];

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial    = {rem[15:0], dq[31]};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? (trial - {1'b0, dvs}) : trial;
    dq_next  = {dq[30:0], qbit};
  end

  always_comb begin
    unique case (state)
      S_MLX:   begin mul_a = ux; mul_b = bx; end
      S_MLY:   begin mul_a = uy; mul_b = by; end
      S_MSX:   begin mul_a = ux; mul_b = {12'd0, ws}; end
      default: begin mul_a = uy; mul_b = {12'd0, ws}; end
    endcase
  end

  assign lx_sat = (|prod[51:44]) ? grt_pkg::SAT32 : prod[43:12];
  assign s_sat  = (|prod[51:32]) ? grt_pkg::SAT32 : prod[31:0];

  always_comb begin
    step_x   = (lx < ly);
    col_next = col;
    row_next = row;
    if (step_x) col_next = nx ? col - 14'sd1 : col + 14'sd1;
    else        row_next = ny ? row - 14'sd1 : row + 14'sd1;
    leave = col_next[13] || row_next[13] ||
            (col_next[12:0] >= 13'(w_eff)) || (row_next[12:0] >= 13'(h_eff));
  end

  assign raddr = {row_next[grt_pkg::ROW_W-1:0], col_next[grt_pkg::COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[cell_index[grt_pkg::ADDR_W-1:0]] <= cell_value;
    rdata <= tile_mem[raddr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * {12'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 7'd64;
      map_height <= 7'd64;
      wall_size  <= 8'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        grt_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data[6:0];
        grt_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data[6:0];
        grt_pkg::CFG_WALL_SIZE:  wall_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      div_sel   <= 2'd0;
      div_cnt   <= '0;
      steps     <= '0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && kind == grt_pkg::KIND_CAST) begin
            px      <= origin_x;
            py      <= origin_y;
            nx      <= dir_x[15];
            ny      <= dir_y[15];
            mx      <= mx_in;
            my      <= my_in;
            dq      <= 32'h8000_0000;
            rem     <= '0;
            dvs     <= mx_in;
            div_sel <= 2'd0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == grt_pkg::DIV_CNT_W'(grt_pkg::DIV_STEPS - 1)) begin
            rem     <= '0;
            div_sel <= div_sel + 2'd1;
            unique case (div_sel)
              2'd0: begin
                ux  <= (mx == 16'd0) ? grt_pkg::SAT32 : dq_next;
                dq  <= 32'h8000_0000;
                dvs <= my;
              end
              2'd1: begin
                uy  <= (my == 16'd0) ? grt_pkg::SAT32 : dq_next;
                dq  <= {20'd0, px[23:12]};
                dvs <= {8'd0, ws};
              end
              2'd2: begin
                col <= {2'b00, dq_next[11:0]};
                bx  <= nx ? {rem_next[7:0], frac_x}
                          : ({ws - rem_next[7:0], 12'd0} - {8'd0, frac_x});
                dq  <= {20'd0, py[23:12]};
              end
              default: begin
                row   <= {2'b00, dq_next[11:0]};
                by    <= ny ? {rem_next[7:0], frac_y}
                            : ({ws - rem_next[7:0], 12'd0} - {8'd0, frac_y});
                state <= S_MLX;
              end
            endcase
          end else begin
            dq  <= dq_next;
            rem <= rem_next;
          end
        end
        S_MLX: state <= S_MLY;
        S_MLY: begin
          lx    <= lx_sat;
          state <= S_MSX;
        end
        S_MSX: begin
          ly    <= lx_sat;
          state <= S_MSY;
        end
        S_MSY: begin
          sx    <= s_sat;
          state <= S_MEND;
        end
        S_MEND: begin
          sy    <= s_sat;
          steps <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          col   <= col_next;
          row   <= row_next;
          xs    <= step_x;
          steps <= steps + 1'b1;
          if (step_x) begin
            run_len <= lx;
            lx      <= grt_pkg::sat_add(lx, sx);
          end else begin
            run_len <= ly;
            ly      <= grt_pkg::sat_add(ly, sy);
          end
          if (leave) begin
            found      <= 1'b0;
            found_kind <= 8'd0;
            state      <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rdata != 8'd0) begin
            found      <= 1'b1;
            found_kind <= rdata;
            state      <= S_DONE;
          end else if (steps == grt_pkg::STEP_CNT_W'(grt_pkg::STEP_LIMIT)) begin
            found      <= 1'b0;
            found_kind <= 8'd0;
            state      <= S_DONE;
          end else begin
            state <= S_STEP;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid    <= 1'b1;
            hit          <= found;
            wall_kind    <= found_kind;
            hit_col      <= found ? col[5:0] : 6'd0;
            hit_row      <= found ? row[5:0] : 6'd0;
            ray_distance <= run_len;
            x_side       <= xs;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= grt_pkg::STEP_CNT_W'(grt_pkg::STEP_LIMIT))
    else $error("step count past limit");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == grt_pkg::KIND_WRITE && !res_valid) |=> !res_valid)
    else $error("map write produced a result");

  a_chk_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (!col[13] && !row[13] &&
                          col[12:0] < 13'(w_eff) && row[12:0] < 13'(h_eff)))
    else $error("map read outside configured size");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

endmodule
